### hdl/mvkb_pkg.sv
// Shared types, bus map and parameter defaults for the video and keyboard bridge.
package mvkb_pkg;

  localparam int DefFrameWidth  = 320;
  localparam int DefFrameHeight = 200;
  localparam int DefKeyDepth    = 16;

  localparam logic [31:0] VRAM_BASE   = 32'h0008_2000;
  localparam logic [31:0] PAGE_REG    = 32'h0008_0000;
  localparam logic [31:0] CONSOLE_REG = 32'h0008_0004;
  localparam logic [31:0] KEY_REG     = 32'h0008_0020;
  localparam logic [31:0] STATUS_REG  = 32'h0008_0024;
  localparam logic [31:0] MOUSE_X_REG = 32'h0008_0028;
  localparam logic [31:0] MOUSE_Y_REG = 32'h0008_002C;
  localparam logic [31:0] BUTTON_REG  = 32'h0008_0030;
  localparam logic [3:0]  LANE_MASK   = 4'h F;

  typedef enum logic [1:0] {
    OP_BUS   = 2'd0,
    OP_KEY   = 2'd1,
    OP_MOUSE = 2'd2,
    OP_PIXEL = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [3:0]  byte_enable;
    logic        read_enable;
    logic [7:0]  key_code;
    logic [8:0]  mouse_x_in;
    logic [7:0]  mouse_y_in;
    logic        mouse_left_in;
    logic [15:0] pixel_index;
  } item_t;

endpackage

### hdl/mmio_video_keyboard_bridge_unit.sv
// Memory-mapped video, console, keyboard and mouse bridge with a two-stage pipeline.
//
// Usage:
//   One request enters on the s_axis channel: tuser carries the opcode (bus access,
//   key push, mouse update, pixel fetch) and tdata the remaining fields. Every
//   request yields exactly one result on the m_axis channel, in order.
//   A request passes the first stage, then the output register. One request is
//   accepted every cycle unless the clear pass or a stalled output holds
//   s_axis_tready low. The frame store and the key queue are single memories with
//   one access per request and registered read data, which sets the two-stage
//   depth. A bus write and a later pixel fetch of the same word see the new data.
//   After reset the frame store is cleared one word per cycle, all of its
//   FRAME_WIDTH*FRAME_HEIGHT words (64000 at the defaults); s_axis_tready stays low
//   during that pass. Shown page, pointer, button and key queue reset to zero, the
//   dirty flag to one. When the receiver stalls, the result holds in the output
//   register, one more request is taken into the first stage, and then s_axis_tready
//   drops until the result is taken.
module mmio_video_keyboard_bridge_unit #(
  parameter int FRAME_WIDTH  = mvkb_pkg::DefFrameWidth,
  parameter int FRAME_HEIGHT = mvkb_pkg::DefFrameHeight,
  parameter int KEY_DEPTH    = mvkb_pkg::DefKeyDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // address, write_data, byte_enable, read_enable, key_code, mouse_x_in,
  // mouse_y_in, mouse_left_in, pixel_index, zero fill
  input  logic [111:0] s_axis_tdata_i,
  // opcode
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // read_data, console_valid, console_char, pixel_data, frame_dirty,
  // key_dropped, key_level
  output logic [63:0]  m_axis_tdata_o
);

  localparam int PagePixels = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int PageBytes  = PagePixels * 2;
  localparam int StoreBytes = PageBytes * 2;
  localparam int StoreWords = StoreBytes / 4;
  localparam int Aw         = $clog2(StoreWords);
  localparam int Kiw        = $clog2(KEY_DEPTH);
  localparam int Kcw        = $clog2(KEY_DEPTH + 1);

  logic [31:0]    fb_mem [StoreWords];
  logic [7:0]     key_mem [KEY_DEPTH];

  logic           clr_active_q;
  logic [Aw-1:0]  clr_idx_q;

  logic           s1_valid_q;
  mvkb_pkg::item_t s1_q;
  logic           s1_move;

  logic           out_valid_q;
  logic           s2_load;

  logic           shown_page_q, shown_page_d;
  logic           dirty_q, dirty_d;
  logic [Kiw-1:0] key_head_q, key_head_d;
  logic [Kcw-1:0] key_count_q, key_count_d;
  logic [8:0]     pointer_x_q, pointer_x_d;
  logic [7:0]     pointer_y_q, pointer_y_d;
  logic           left_button_q, left_button_d;

  logic [31:0]    word_addr;
  logic [31:0]    store_off;
  logic           in_store;
  logic           bus_wr;
  logic           fb_we;
  logic           con_valid;
  logic [7:0]     con_char;
  logic           key_pop;
  logic           key_push;
  logic           key_drop;
  logic [31:0]    rdata_base;
  logic           pix_hit;
  logic [31:0]    pix_byte;
  logic [31:0]    tail_sum;
  logic [31:0]    tail_wrap;
  logic [Kiw-1:0] key_tail;
  logic [Aw-1:0]  fb_addr;
  logic [31:0]    level_ext;

  logic [31:0]    rdata_q;
  logic           key_hit_q;
  logic           con_valid_q;
  logic [7:0]     con_char_q;
  logic           pix_hit_q;
  logic           pix_half_q;
  logic           dirty_out_q;
  logic           dropped_q;
  logic [4:0]     level_q;
  logic [31:0]    fb_rd_q;
  logic [7:0]     key_rd_q;
  logic [31:0]    read_data;
  logic [15:0]    pixel_data;

  assign s2_load = !out_valid_q || m_axis_tready_i;
  assign s1_move = s1_valid_q && s2_load;
  assign s_axis_tready_o = !clr_active_q && (!s1_valid_q || s2_load);

  always_comb begin
    word_addr     = {s1_q.address[31:2], 2'b00};
    store_off     = s1_q.address - mvkb_pkg::VRAM_BASE;
    in_store      = store_off < 32'(StoreBytes);
    bus_wr        = (s1_q.opcode == mvkb_pkg::OP_BUS) &&
                    ((s1_q.byte_enable & mvkb_pkg::LANE_MASK) != 4'd0);
    fb_we         = 1'b0;
    con_valid     = 1'b0;
    con_char      = 8'd0;
    key_pop       = 1'b0;
    key_push      = 1'b0;
    key_drop      = 1'b0;
    rdata_base    = 32'd0;
    pix_hit       = 1'b0;
    pix_byte      = (shown_page_q ? 32'(PageBytes) : 32'd0) + {15'd0, s1_q.pixel_index, 1'b0};
    shown_page_d  = shown_page_q;
    dirty_d       = dirty_q;
    pointer_x_d   = pointer_x_q;
    pointer_y_d   = pointer_y_q;
    left_button_d = left_button_q;

    unique case (s1_q.opcode)
      mvkb_pkg::OP_BUS: begin
        if (bus_wr) begin
          if (in_store) begin
            fb_we   = 1'b1;
            dirty_d = 1'b1;
          end else if (word_addr == mvkb_pkg::PAGE_REG) begin
            if (s1_q.byte_enable[0]) begin
              shown_page_d = s1_q.write_data[0];
              dirty_d      = 1'b1;
            end
          end else if (word_addr == mvkb_pkg::CONSOLE_REG) begin
            if (s1_q.byte_enable[s1_q.address[1:0]]) begin
              con_valid = 1'b1;
              con_char  = s1_q.write_data[8*s1_q.address[1:0] +: 8];
            end
          end
        end
        if (s1_q.read_enable) begin
          if (word_addr == mvkb_pkg::KEY_REG) begin
            key_pop = key_count_q != '0;
          end else if (word_addr == mvkb_pkg::STATUS_REG) begin
            rdata_base = {31'd0, key_count_q != '0};
          end else if (word_addr == mvkb_pkg::MOUSE_X_REG) begin
            rdata_base = {23'd0, pointer_x_q};
          end else if (word_addr == mvkb_pkg::MOUSE_Y_REG) begin
            rdata_base = {24'd0, pointer_y_q};
          end else if (word_addr == mvkb_pkg::BUTTON_REG) begin
            rdata_base = {31'd0, left_button_q};
          end
        end
      end
      mvkb_pkg::OP_KEY: begin
        if (32'(key_count_q) < 32'(KEY_DEPTH)) begin
          key_push = 1'b1;
        end else begin
          key_drop = 1'b1;
        end
      end
      mvkb_pkg::OP_MOUSE: begin
        if (32'(s1_q.mouse_x_in) < 32'(FRAME_WIDTH)) begin
          pointer_x_d = s1_q.mouse_x_in;
        end
        if (32'(s1_q.mouse_y_in) < 32'(FRAME_HEIGHT)) begin
          pointer_y_d = s1_q.mouse_y_in;
        end
        left_button_d = s1_q.mouse_left_in;
      end
      mvkb_pkg::OP_PIXEL: begin
        if (32'(s1_q.pixel_index) < 32'(PagePixels)) begin
          pix_hit = 1'b1;
          if (32'(s1_q.pixel_index) == 32'(PagePixels - 1)) begin
            dirty_d = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    fb_addr = fb_we ? store_off[Aw+1:2] : pix_byte[Aw+1:2];

    tail_sum  = 32'(key_head_q) + 32'(key_count_q);
    tail_wrap = (tail_sum >= 32'(KEY_DEPTH)) ? tail_sum - 32'(KEY_DEPTH) : tail_sum;
    key_tail  = tail_wrap[Kiw-1:0];

    key_head_d  = key_head_q;
    key_count_d = key_count_q;
    if (key_pop) begin
      key_head_d  = (32'(key_head_q) == 32'(KEY_DEPTH - 1)) ? '0 : key_head_q + 1'b1;
      key_count_d = key_count_q - 1'b1;
    end else if (key_push) begin
      key_count_d = key_count_q + 1'b1;
    end
    level_ext = 32'(key_count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_idx_q    <= '0;
    end else if (clr_active_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == Aw'(StoreWords - 1)) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_active_q) begin
      fb_mem[clr_idx_q] <= 32'd0;
    end else if (s1_move && fb_we) begin
      for (int l = 0; l < 4; l++) begin
        if (s1_q.byte_enable[l]) begin
          fb_mem[fb_addr][8*l +: 8] <= s1_q.write_data[8*l +: 8];
        end
      end
    end else if (s1_move && pix_hit) begin
      fb_rd_q <= fb_mem[fb_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && key_push) begin
      key_mem[key_tail] <= s1_q.key_code;
    end else if (s1_move && key_pop) begin
      key_rd_q <= key_mem[key_head_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      shown_page_q  <= 1'b0;
      dirty_q       <= 1'b1;
      key_head_q    <= '0;
      key_count_q   <= '0;
      pointer_x_q   <= '0;
      pointer_y_q   <= '0;
      left_button_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        s1_valid_q <= s_axis_tvalid_i;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s2_load) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_move) begin
        shown_page_q  <= shown_page_d;
        dirty_q       <= dirty_d;
        key_head_q    <= key_head_d;
        key_count_q   <= key_count_d;
        pointer_x_q   <= pointer_x_d;
        pointer_y_q   <= pointer_y_d;
        left_button_q <= left_button_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      s1_q.opcode        <= mvkb_pkg::opcode_e'(s_axis_tuser_i);
      s1_q.address       <= s_axis_tdata_i[31:0];
      s1_q.write_data    <= s_axis_tdata_i[63:32];
      s1_q.byte_enable   <= s_axis_tdata_i[67:64];
      s1_q.read_enable   <= s_axis_tdata_i[68];
      s1_q.key_code      <= s_axis_tdata_i[76:69];
      s1_q.mouse_x_in    <= s_axis_tdata_i[85:77];
      s1_q.mouse_y_in    <= s_axis_tdata_i[93:86];
      s1_q.mouse_left_in <= s_axis_tdata_i[94];
      s1_q.pixel_index   <= s_axis_tdata_i[110:95];
    end
    if (s1_move) begin
      rdata_q     <= rdata_base;
      key_hit_q   <= key_pop;
      con_valid_q <= con_valid;
      con_char_q  <= con_char;
      pix_hit_q   <= pix_hit;
      pix_half_q  <= pix_byte[1];
      dirty_out_q <= dirty_q;
      dropped_q   <= key_drop;
      level_q     <= level_ext[4:0];
    end
  end

  assign read_data  = key_hit_q ? {24'd0, key_rd_q} : rdata_q;
  assign pixel_data = !pix_hit_q ? 16'd0 : (pix_half_q ? fb_rd_q[31:16] : fb_rd_q[15:0]);

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {level_q, dropped_q, dirty_out_q, pixel_data,
                            con_char_q, con_valid_q, read_data};

endmodule
